FILE: src/sprs_pkg.sv
`timescale 1ns / 1ps
package sprs_pkg;

  localparam int REG_COUNT_DEF = 256;

  localparam int IDENT_W = 24;
  localparam int CFG_W   = 24;
  localparam int BYTE_W  = 8;

  localparam logic CFG_SERIALIZER_MODE = 1'b0;
  localparam logic CFG_PANEL_IDENTITY  = 1'b1;

  localparam logic [7:0] ID_FIRST    = 8'hDA;
  localparam logic [7:0] ID_LAST     = 8'hDC;
  localparam logic [7:0] ENTER_REGS  = 8'hDE;
  localparam logic [7:0] ADDR_MASK   = 8'h7F;
  localparam logic [7:0] STATUS_ADDR = 8'h15;
  localparam logic [7:0] READY_BIT   = 8'h01;
  localparam logic [IDENT_W-1:0] IDENT_RESET = 24'hB3C21A;

  typedef struct packed {
    logic capture;
    logic exec;
  } sprs_cmd_t;

  typedef struct packed {
    logic out_busy;
  } sprs_status_t;

endpackage

FILE: src/sprs_in_if.sv
`timescale 1ns / 1ps
interface sprs_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] mosi_byte;

  modport source (output valid, output cmd, output mosi_byte, input ready);
  modport sink   (input valid, input cmd, input mosi_byte, output ready);
endinterface

FILE: src/sprs_out_if.sv
`timescale 1ns / 1ps
interface sprs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] miso_byte;

  modport source (output valid, output miso_byte, input ready);
  modport sink   (input valid, input miso_byte, output ready);
endinterface

FILE: src/spi_panel_register_slave.sv
`timescale 1ns / 1ps
// The input transaction is captured with its register file read, then executed with the
// register file update into the registered result. A new transaction is not accepted until
// the last one has executed; it is held off while the result register is full and not taken.
// Reset (synchronous, active low) clears control state and all register file valid bits
// at once, so the register file reads as zero with no clearing pass.
module spi_panel_register_slave
  import sprs_pkg::*;
#(
  parameter int REG_COUNT = REG_COUNT_DEF
)(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  sprs_in_if.sink          in_ch,
  sprs_out_if.source       out_ch
);

  sprs_cmd_t    dp_cmd;
  sprs_status_t dp_status;

  sprs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  sprs_datapath #(
    .REG_COUNT (REG_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_cmd        (in_ch.cmd),
    .in_mosi_byte  (in_ch.mosi_byte),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_miso_byte (out_ch.miso_byte),
    .cmd           (dp_cmd),
    .status        (dp_status)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a transaction is in work");

  a_exec_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.exec |=> out_ch.valid)
    else $error("executed transaction produced no result");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({dp_cmd.capture, dp_cmd.exec}))
    else $error("capture and exec issued together");

  a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.exec |-> !(out_ch.valid && !out_ch.ready))
    else $error("result overwritten before it was taken");

endmodule

FILE: src/sprs_ctrl.sv
`timescale 1ns / 1ps
module sprs_ctrl
  import sprs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  sprs_status_t status,
  output sprs_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!status.out_busy) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/sprs_datapath.sv
`timescale 1ns / 1ps
module sprs_datapath
  import sprs_pkg::*;
#(
  parameter int REG_COUNT = REG_COUNT_DEF
)(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_cmd,
  input  logic [BYTE_W-1:0] in_mosi_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_miso_byte,
  input  sprs_cmd_t         cmd,
  output sprs_status_t      status
);

  localparam int ADDR_W = $clog2(REG_COUNT);

  logic [BYTE_W-1:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;

  logic               mode_r;
  logic [IDENT_W-1:0] ident_r;
  logic [7:0]         latch_r, latch_nxt;
  logic               pending_r, pending_nxt;
  logic               cmd_q_r;
  logic [7:0]         byte_q_r;
  logic [7:0]         rdata_r;
  logic               rvalid_r;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;

  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [7:0]         wr_data;
  logic               mem_we;
  logic [7:0]         rd_val;
  logic [1:0]         id_off;
  logic [7:0]         id_byte;

  assign rd_addr = in_cmd ? STATUS_ADDR[ADDR_W-1:0] : (latch_r & ADDR_MASK);
  assign rd_val  = rvalid_r ? rdata_r : 8'h00;
  assign id_off  = latch_r[1:0] - ID_FIRST[1:0];

  always_comb begin
    case (id_off)
      2'd0:    id_byte = ident_r[7:0];
      2'd1:    id_byte = ident_r[15:8];
      2'd2:    id_byte = ident_r[23:16];
      default: id_byte = 8'h00;
    endcase
  end

  always_comb begin
    latch_nxt     = latch_r;
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    mem_we        = 1'b0;
    wr_addr       = latch_r[ADDR_W-1:0];
    wr_data       = byte_q_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = 8'h00;
      if (cmd_q_r) begin
        if (!mode_r && pending_r && latch_r == ENTER_REGS) begin
          mem_we  = 1'b1;
          wr_addr = STATUS_ADDR[ADDR_W-1:0];
          wr_data = rd_val | READY_BIT;
        end
        pending_nxt = 1'b0;
      end else if (!mode_r && pending_r && (latch_r inside {[ID_FIRST:ID_LAST]})) begin
        out_byte_nxt = id_byte;
        pending_nxt  = 1'b0;
      end else if (!mode_r && pending_r && latch_r[7]) begin
        out_byte_nxt = rd_val;
        pending_nxt  = 1'b0;
      end else if (!pending_r) begin
        latch_nxt   = byte_q_r;
        pending_nxt = 1'b1;
      end else begin
        mem_we    = 1'b1;
        latch_nxt = latch_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.capture) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q_r  <= in_cmd;
      byte_q_r <= in_mosi_byte;
    end
    out_byte_r <= out_byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      rvalid_r    <= 1'b0;
      mode_r      <= 1'b0;
      ident_r     <= IDENT_RESET;
      latch_r     <= 8'h00;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.capture) begin
        rvalid_r <= valid_r[rd_addr];
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SERIALIZER_MODE: mode_r  <= cfg_wdata[0];
          CFG_PANEL_IDENTITY:  ident_r <= cfg_wdata[IDENT_W-1:0];
          default: ;
        endcase
      end
      latch_r     <= latch_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_miso_byte   = out_byte_r;
  assign status.out_busy = out_valid_r && !out_ready;

endmodule

FILE: tb/spi_panel_register_slave_test.sv
`timescale 1ns / 1ps
module spi_panel_register_slave_test
  import sprs_pkg::*;
();

  localparam logic XFER_BYTE     = 1'b0;
  localparam logic XFER_DEASSERT = 1'b1;
  localparam logic [8:0] CS_END  = {XFER_DEASSERT, 8'h00};
  localparam int PHASE_ITEMS     = 275;
  localparam int NUM_PHASES      = 6;

  class panel_register_shadow;
    bit        serializer;
    bit [23:0] identity;
    bit [7:0]  regs [REG_COUNT_DEF];
    bit [7:0]  latch;
    bit        pending;
    bit [7:0]  expected_miso [$];
    int        errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      latch      = '0;
      pending    = 1'b0;
      serializer = 1'b0;
      identity   = IDENT_RESET;
      errors     = 0;
    endfunction

    function void write_cfg(logic idx, logic [CFG_W-1:0] value);
      if (idx == CFG_SERIALIZER_MODE) begin
        serializer = value[0];
      end else begin
        identity = value[IDENT_W-1:0];
      end
    endfunction

    function void note_input(logic deassert, logic [7:0] data);
      bit [7:0] miso;
      bit [1:0] sel;
      miso = '0;
      if (deassert) begin
        if (!serializer && pending && latch == ENTER_REGS) begin
          regs[STATUS_ADDR] |= READY_BIT;
        end
        pending = 1'b0;
      end else if (!serializer && pending && latch >= ID_FIRST && latch <= ID_LAST) begin
        sel     = 2'(latch - ID_FIRST);
        miso    = identity[sel*8 +: 8];
        pending = 1'b0;
      end else if (!serializer && pending && latch[7]) begin
        miso    = regs[latch & ADDR_MASK];
        pending = 1'b0;
      end else if (!pending) begin
        latch   = data;
        pending = 1'b1;
      end else begin
        regs[latch] = data;
        latch       = latch + 8'd1;
      end
      expected_miso.push_back(miso);
    endfunction

    task report(string what);
      errors++;
      $display("%0t ERROR %s", $time, what);
    endtask

    task check_result(logic [7:0] got);
      bit [7:0] want;
      if (expected_miso.size() == 0) begin
        report($sformatf("unexpected miso_byte %02h", got));
      end else begin
        want = expected_miso.pop_front();
        if (got !== want) begin
          report($sformatf("miso_byte %02h, expected %02h", got, want));
        end
      end
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  sprs_in_if  in_ch();
  sprs_out_if out_ch();

  panel_register_shadow shadow = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  logic [8:0] directed_items [$];

  spi_panel_register_slave DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send(logic kind, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= kind;
    in_ch.mosi_byte <= data;
    do @(posedge clk); while (!in_ch.ready);
    shadow.note_input(kind, data);
    items_sent++;
  endtask

  task automatic send_directed();
    foreach (directed_items[i]) send(directed_items[i][8], directed_items[i][7:0]);
  endtask

  task automatic write_cfg(logic idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    shadow.write_cfg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (shadow.expected_miso.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one chip-select frame: deassert, command byte, then data bytes
  task automatic send_frame();
    int pick;
    int len;
    logic [7:0] command;
    pick = $urandom_range(99);
    len  = $urandom_range(0, 6);
    if (pick < 25) begin
      command = 8'($urandom_range(8'h7F));
    end else if (pick < 30) begin
      command = 8'($urandom_range(8'h78, 8'h7F));
    end else if (pick < 35) begin
      command = 8'($urandom_range(8'hF8, 8'hFF));
    end else if (pick < 55) begin
      command = 8'($urandom_range(8'h80, 8'hFF));
    end else if (pick < 70) begin
      command = 8'($urandom_range(ID_FIRST, ID_LAST));
    end else if (pick < 78) begin
      command = ENTER_REGS;
    end else begin
      command = 8'($urandom);
    end
    send(XFER_DEASSERT, 8'($urandom));
    send(XFER_BYTE, command);
    repeat (len) send(XFER_BYTE, 8'($urandom));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send(1'($urandom_range(1)), 8'($urandom));
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) shadow.check_result(out_ch.miso_byte);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : main
    int phase;
    int target;
    bit paused;
    paused          = 1'b0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_SERIALIZER_MODE;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= XFER_BYTE;
    in_ch.mosi_byte <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1: write_cfg(CFG_PANEL_IDENTITY, 24'hFFFFFF);
        2: write_cfg(CFG_SERIALIZER_MODE, 24'd1);
        3: begin
          write_cfg(CFG_SERIALIZER_MODE, 24'd0);
          write_cfg(CFG_PANEL_IDENTITY, 24'd0);
        end
        4: begin
          write_cfg(CFG_SERIALIZER_MODE, 24'd1);
          write_cfg(CFG_PANEL_IDENTITY, 24'($urandom));
        end
        5: begin
          write_cfg(CFG_SERIALIZER_MODE, 24'd0);
          write_cfg(CFG_PANEL_IDENTITY, 24'($urandom));
        end
        default: ;
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      target = items_sent + PHASE_ITEMS;

      if (phase == 0) begin
        // identity bytes, register write crossing into the read range,
        // register read, ready bit via 0xDE, 0xDE read, bare deassert
        directed_items = '{
          {XFER_BYTE, 8'hDA}, {XFER_BYTE, 8'h55}, CS_END,
          {XFER_BYTE, 8'hDB}, {XFER_BYTE, 8'hAA}, CS_END,
          {XFER_BYTE, 8'hDC}, {XFER_BYTE, 8'hFF}, CS_END,
          {XFER_BYTE, 8'h00}, {XFER_BYTE, 8'hC3}, CS_END,
          {XFER_BYTE, 8'h7E}, {XFER_BYTE, 8'hA5}, {XFER_BYTE, 8'h5A},
          {XFER_BYTE, 8'h11}, CS_END,
          {XFER_BYTE, 8'hFF}, {XFER_BYTE, 8'h00}, CS_END,
          {XFER_BYTE, 8'hDE}, CS_END, {XFER_BYTE, 8'h95}, {XFER_BYTE, 8'h00}, CS_END,
          {XFER_BYTE, 8'hDE}, {XFER_BYTE, 8'h77}, CS_END, CS_END
        };
        send_directed();
      end else if (phase == 2) begin
        // serializer: address wrap, identity and 0xDE commands are plain writes
        directed_items = '{
          CS_END, {XFER_BYTE, 8'hFE}, {XFER_BYTE, 8'h01}, {XFER_BYTE, 8'h02},
          {XFER_BYTE, 8'h03}, CS_END,
          {XFER_BYTE, 8'hDA}, {XFER_BYTE, 8'h99}, CS_END,
          {XFER_BYTE, 8'hDE}, CS_END, {XFER_BYTE, 8'h95}, {XFER_BYTE, 8'h00}
        };
        send_directed();
      end

      while (items_sent < target) begin
        if ($urandom_range(9) == 0) begin
          send_noise();
        end else begin
          send_frame();
        end
        if (phase == 1 && !paused && items_sent >= target - PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
      drain();
    end

    if (shadow.errors == 0) begin
      $display("spi_panel_register_slave verification clean");
    end else begin
      $display("spi_panel_register_slave verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("spi_panel_register_slave verification failed");
    $finish;
  end

endmodule
